// File: design/ckbf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ckbf_pkg
// Shared constants, widths, structs and the back-end state type of the
// canonical b-mer Bloom filter.
// ----------------------------------------------------------------------------
package ckbf_pkg;

  localparam int MAX_BMER        = 32;
  localparam int FILTERS         = 4;
  localparam int MAX_FILTER_BITS = 262144;

  localparam int LEN_W   = $clog2(MAX_BMER + 1);
  localparam int IDX_W   = $clog2(MAX_BMER);
  localparam int KADDR_W = IDX_W + 1;              // bank bit + byte index
  localparam int FIDX_W  = $clog2(FILTERS);
  localparam int POS_W   = $clog2(MAX_FILTER_BITS);
  localparam int MOD_W   = $clog2(MAX_FILTER_BITS + 1);
  localparam int BADDR_W = FIDX_W + POS_W;
  localparam int FWORD_W = 32;
  localparam int FSEL_W  = $clog2(FWORD_W);
  localparam int FWORDS  = FILTERS * MAX_FILTER_BITS / FWORD_W;
  localparam int FA_W    = $clog2(FWORDS);
  localparam int HC_W    = 5;
  localparam int CFG_W   = 19;

  localparam logic [63:0] MIX_M = 64'hc6a4a7935bd1e995;
  localparam int          MIX_R = 47;

  localparam logic [1:0] REG_BMER_LEN    = 2'd0;
  localparam logic [1:0] REG_HASH_COUNT  = 2'd1;
  localparam logic [1:0] REG_FILTER_BITS = 2'd2;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_QUERY  = 1'b1;

  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic [HC_W-1:0]  hash_count;
    logic [MOD_W-1:0] modulus;
  } cfg_t;

  typedef struct packed {
    logic              mode;
    logic [FIDX_W-1:0] fidx;
    logic [LEN_W-1:0]  len;
    logic              bank;
  } job_t;

  typedef struct packed {
    logic             en;
    logic [KADDR_W-1:0] addr;
    logic [7:0]       data;
  } kwr_t;

  typedef enum logic [4:0] {
    B_CLEAR, B_IDLE, B_SCAN_RD, B_SCAN_CMP, B_LENM, B_SEED, B_BYTE_RD,
    B_BYTE_GET, B_WMUL1, B_WMUL2, B_HMUL, B_TMUL, B_FIN, B_DIV, B_MEM_RD,
    B_MEM_CHK, B_NEXT, B_DONE
  } back_state_t;

endpackage : ckbf_pkg
`default_nettype wire

// File: design/ckbf_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ckbf_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module ckbf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule : ckbf_ram
`default_nettype wire

// File: design/ckbf_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ckbf_front
// Takes sequence words, uppercases and stores them in a two-bank b-mer
// buffer, and queues one job per completed b-mer for the back end.
// ----------------------------------------------------------------------------
module ckbf_front
  import ckbf_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire cfg_t              cfg,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [7:0]        in_tdata,   // [7:0] base
  input  wire logic [2:0]        in_tuser,   // [0] mode, [2:1] filter_index
  input  wire logic              clearing,
  output kwr_t                   kwr,
  output logic                   job_valid,
  output job_t                   job,
  input  wire logic              job_pop
);

  logic [IDX_W-1:0] byte_cnt_r, byte_cnt_nxt;
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       cnt_r, cnt_nxt;
  job_t             q_r [2];
  logic             accept, push;
  logic [7:0]       ucase;
  logic [LEN_W-1:0] filled;

  assign in_tready = !clearing && (cnt_r != 2'd2);
  assign accept    = in_tvalid && in_tready;
  assign ucase     = (in_tdata >= "a" && in_tdata <= "z") ? in_tdata - 8'd32 : in_tdata;
  assign filled    = LEN_W'(byte_cnt_r) + LEN_W'(1);
  assign push      = accept && (filled >= cfg.len);

  assign kwr.en   = accept;
  assign kwr.addr = {wr_ptr_r, byte_cnt_r};
  assign kwr.data = ucase;

  assign job_valid = (cnt_r != 2'd0);
  assign job       = q_r[rd_ptr_r];

  always_comb begin
    byte_cnt_nxt = byte_cnt_r;
    wr_ptr_nxt   = wr_ptr_r;
    rd_ptr_nxt   = rd_ptr_r;
    cnt_nxt      = cnt_r;
    if (accept) begin
      byte_cnt_nxt = push ? '0 : byte_cnt_r + IDX_W'(1);
    end
    if (push) begin
      wr_ptr_nxt = !wr_ptr_r;
    end
    if (job_pop) begin
      rd_ptr_nxt = !rd_ptr_r;
    end
    case ({push, job_pop})
      2'b10:   cnt_nxt = cnt_r + 2'd1;
      2'b01:   cnt_nxt = cnt_r - 2'd1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_cnt_r <= '0;
      wr_ptr_r   <= 1'b0;
      rd_ptr_r   <= 1'b0;
      cnt_r      <= '0;
    end else begin
      byte_cnt_r <= byte_cnt_nxt;
      wr_ptr_r   <= wr_ptr_nxt;
      rd_ptr_r   <= rd_ptr_nxt;
      cnt_r      <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= '{mode: in_tuser[0],
                         fidx: FIDX_W'(in_tuser[2:1] % FILTERS),
                         len:  cfg.len,
                         bank: wr_ptr_r};
    end
  end

endmodule : ckbf_front
`default_nettype wire

// File: design/ckbf_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ckbf_mul
// 64-bit multiply by the mix constant, low 64 bits, from three 32x32
// partial products on one shared multiplier.
// ----------------------------------------------------------------------------
module ckbf_mul
  import ckbf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        req,
  input  wire logic [63:0] opnd,
  output logic             done,
  output logic [63:0]      res
);

  logic [2:0]  ph_r, ph_nxt;
  logic [63:0] a_r, acc_r, prod_r;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mprod;

  always_comb begin
    case (ph_r)
      3'd2:    begin mul_a = a_r[63:32]; mul_b = MIX_M[31:0];  end
      3'd3:    begin mul_a = a_r[31:0];  mul_b = MIX_M[63:32]; end
      default: begin mul_a = a_r[31:0];  mul_b = MIX_M[31:0];  end
    endcase
  end

  assign mprod = 64'(mul_a) * 64'(mul_b);
  assign done  = (ph_r == 3'd4);
  assign res   = acc_r + {prod_r[31:0], 32'b0};

  always_comb begin
    case (ph_r)
      3'd0:    ph_nxt = req ? 3'd1 : 3'd0;
      3'd4:    ph_nxt = 3'd0;
      default: ph_nxt = ph_r + 3'd1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= '0;
    end else begin
      ph_r <= ph_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (ph_r)
      3'd0: begin
        a_r <= opnd;
      end
      3'd1: begin
        prod_r <= mprod;
      end
      3'd2: begin
        acc_r  <= prod_r;
        prod_r <= {32'b0, mprod[31:0]};
      end
      3'd3: begin
        acc_r  <= acc_r + {prod_r[31:0], 32'b0};
        prod_r <= {32'b0, mprod[31:0]};
      end
      default: begin
        acc_r <= acc_r;
      end
    endcase
  end

endmodule : ckbf_mul
`default_nettype wire

// File: design/ckbf_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ckbf_div
// Restoring remainder of a 64-bit hash by the filter size, one bit a cycle.
// ----------------------------------------------------------------------------
module ckbf_div
  import ckbf_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             req,
  input  wire logic [63:0]      dividend,
  input  wire logic [MOD_W-1:0] divisor,
  output logic                  done,
  output logic [POS_W-1:0]      rem
);

  logic             busy_r;
  logic [6:0]       cnt_r;
  logic [63:0]      q_r;
  logic [MOD_W-1:0] d_r, rem_r;
  logic [MOD_W:0]   trial;

  assign trial = {rem_r, q_r[63]};
  assign done  = busy_r && (cnt_r == 7'd0);
  assign rem   = rem_r[POS_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (!busy_r) begin
      if (req) begin
        busy_r <= 1'b1;
        cnt_r  <= 7'd64;
      end
    end else if (cnt_r == 7'd0) begin
      busy_r <= 1'b0;
    end else begin
      cnt_r <= cnt_r - 7'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!busy_r) begin
      q_r   <= dividend;
      d_r   <= divisor;
      rem_r <= '0;
    end else if (cnt_r != 7'd0) begin
      q_r <= {q_r[62:0], 1'b0};
      if (trial >= {1'b0, d_r}) begin
        rem_r <= MOD_W'(trial - {1'b0, d_r});
      end else begin
        rem_r <= trial[MOD_W-1:0];
      end
    end
  end

endmodule : ckbf_div
`default_nettype wire

// File: design/ckbf_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ckbf_back
// Sequencer for one queued b-mer: canonical scan, hashing under each seed,
// reduction and filter bit access; owns the filter store and result word.
// ----------------------------------------------------------------------------
module ckbf_back
  import ckbf_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire cfg_t               cfg,
  input  wire logic               job_valid,
  input  wire job_t               job,
  output logic                    job_pop,
  output logic                    clearing,
  output logic [KADDR_W-1:0]      kra_addr,
  output logic [KADDR_W-1:0]      krb_addr,
  input  wire logic [7:0]         kd_a,
  input  wire logic [7:0]         kd_b,
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output logic [7:0]              out_tdata   // [0] found
);

  function automatic logic [7:0] comp_base(input logic [7:0] c);
    case (c)
      "A":     return "T";
      "C":     return "G";
      "G":     return "C";
      "T":     return "A";
      default: return "N";
    endcase
  endfunction

  back_state_t state_r, state_nxt;

  logic [IDX_W-1:0]  p_r, k_r, seed_r;
  logic              last_r, swap_r, found_r;
  logic [63:0]       lenm_r, h_r, v_r;
  logic [BADDR_W-1:0] pos_r;
  logic [FA_W-1:0]   clr_r;
  logic              out_valid_r, out_found_r;

  logic              mul_req, mul_done, div_req, div_done;
  logic [63:0]       mul_opnd, mul_res;
  logic [POS_W-1:0]  div_rem;
  logic              fw_en;
  logic [FA_W-1:0]   fw_addr;
  logic [FWORD_W-1:0] fw_data, fr_data;

  logic [LEN_W-1:0]  len, half, mirror_p, mirror_k, k_ext;
  logic [7:0]        cb, byte_c;
  logic              scan_eq, scan_end, in_region, in_words, last_byte, bit_set;
  logic [63:0]       shifted;
  logic              out_free;

  assign len       = job.len;
  assign half      = (len - LEN_W'(1)) >> 1;
  assign mirror_p  = len - LEN_W'(1) - LEN_W'(p_r);
  assign k_ext     = LEN_W'(k_r);
  assign mirror_k  = len - LEN_W'(1) - k_ext;
  assign cb        = comp_base(kd_b);
  assign scan_eq   = (kd_a == cb);
  assign scan_end  = !scan_eq || last_r;
  assign in_region = swap_r && (k_r >= p_r) && (k_ext <= mirror_p);
  assign byte_c    = in_region ? comp_base(kd_a) : kd_a;
  assign in_words  = (k_ext < {len[LEN_W-1:3], 3'b000});
  assign last_byte = (k_ext + LEN_W'(1) == len);
  assign shifted   = {56'b0, byte_c} << {k_r[2:0], 3'b000};
  assign bit_set   = fr_data[pos_r[FSEL_W-1:0]];
  assign out_free  = !out_valid_r || out_tready;

  assign clearing   = (state_r == B_CLEAR);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_found_r};

  ckbf_mul u_mul (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (mul_req),
    .opnd (mul_opnd),
    .done (mul_done),
    .res  (mul_res)
  );

  ckbf_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (div_req),
    .dividend(h_r),
    .divisor (cfg.modulus),
    .done    (div_done),
    .rem     (div_rem)
  );

  ckbf_ram #(.WIDTH(FWORD_W), .DEPTH(FWORDS)) u_store (
    .clk  (clk),
    .we   (fw_en),
    .waddr(fw_addr),
    .wdata(fw_data),
    .raddr(pos_r[BADDR_W-1:FSEL_W]),
    .rdata(fr_data)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_CLEAR:    if (clr_r == FA_W'(FWORDS - 1)) state_nxt = B_IDLE;
      B_IDLE:     if (job_valid) state_nxt = B_SCAN_RD;
      B_SCAN_RD:  state_nxt = B_SCAN_CMP;
      B_SCAN_CMP: state_nxt = scan_end ? B_LENM : B_SCAN_RD;
      B_LENM: begin
        if (mul_done) begin
          state_nxt = (cfg.hash_count == '0) ? B_DONE : B_SEED;
        end
      end
      B_SEED:     state_nxt = B_BYTE_RD;
      B_BYTE_RD:  state_nxt = B_BYTE_GET;
      B_BYTE_GET: begin
        if (in_words) begin
          state_nxt = (k_r[2:0] == 3'd7) ? B_WMUL1 : B_BYTE_RD;
        end else begin
          state_nxt = last_byte ? B_TMUL : B_BYTE_RD;
        end
      end
      B_WMUL1:    if (mul_done) state_nxt = B_WMUL2;
      B_WMUL2:    if (mul_done) state_nxt = B_HMUL;
      B_HMUL:     if (mul_done) state_nxt = last_byte ? B_FIN : B_BYTE_RD;
      B_TMUL:     if (mul_done) state_nxt = B_FIN;
      B_FIN:      if (mul_done) state_nxt = B_DIV;
      B_DIV:      if (div_done) state_nxt = B_MEM_RD;
      B_MEM_RD:   state_nxt = B_MEM_CHK;
      B_MEM_CHK:  state_nxt = B_NEXT;
      B_NEXT: begin
        state_nxt = (LEN_W'(seed_r) + LEN_W'(1) >= LEN_W'(cfg.hash_count)) ? B_DONE : B_SEED;
      end
      B_DONE: begin
        if (job.mode == MODE_INSERT || out_free) state_nxt = B_IDLE;
      end
      default:    state_nxt = B_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    mul_req  = 1'b0;
    mul_opnd = h_r;
    div_req  = 1'b0;
    kra_addr = {job.bank, p_r};
    krb_addr = {job.bank, mirror_p[IDX_W-1:0]};
    fw_en    = 1'b0;
    fw_addr  = pos_r[BADDR_W-1:FSEL_W];
    fw_data  = fr_data | (FWORD_W'(1) << pos_r[FSEL_W-1:0]);
    job_pop  = 1'b0;
    unique case (state_r)
      B_CLEAR: begin
        fw_en   = 1'b1;
        fw_addr = clr_r;
        fw_data = '0;
      end
      B_LENM: begin
        mul_req  = 1'b1;
        mul_opnd = 64'(len);
      end
      B_BYTE_RD, B_BYTE_GET: begin
        kra_addr = {job.bank, in_region ? mirror_k[IDX_W-1:0] : k_r};
      end
      B_WMUL1, B_WMUL2: begin
        mul_req  = 1'b1;
        mul_opnd = v_r;
      end
      B_HMUL, B_TMUL: begin
        mul_req = 1'b1;
      end
      B_FIN: begin
        mul_req  = 1'b1;
        mul_opnd = h_r ^ (h_r >> MIX_R);
      end
      B_DIV:     div_req = 1'b1;
      B_MEM_CHK: fw_en = (job.mode == MODE_INSERT);
      B_DONE:    job_pop = (job.mode == MODE_INSERT) || out_free;
      default: begin
        mul_req = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == B_CLEAR) begin
        clr_r <= clr_r + FA_W'(1);
      end
      if (state_r == B_DONE && job.mode == MODE_QUERY && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (state_r == B_DONE && job.mode == MODE_QUERY && out_free) begin
      out_found_r <= found_r;
    end
    case (state_r)
      B_IDLE: begin
        p_r     <= '0;
        last_r  <= 1'b0;
        found_r <= 1'b1;
        seed_r  <= '0;
      end
      B_SCAN_CMP: begin
        if (scan_end) begin
          swap_r <= ({1'b0, p_r} << 1) < len && (kd_a > cb);
        end else begin
          p_r    <= p_r + IDX_W'(1);
          last_r <= (LEN_W'(p_r) + LEN_W'(1) >= half);
        end
      end
      B_LENM: if (mul_done) lenm_r <= mul_res;
      B_SEED: begin
        h_r <= lenm_r ^ 64'(seed_r);
        k_r <= '0;
      end
      B_BYTE_GET: begin
        if (in_words) begin
          v_r <= ((k_r[2:0] == 3'd0) ? 64'd0 : v_r) | shifted;
          if (k_r[2:0] != 3'd7) k_r <= k_r + IDX_W'(1);
        end else begin
          h_r <= h_r ^ shifted;
          if (!last_byte) k_r <= k_r + IDX_W'(1);
        end
      end
      B_WMUL1: if (mul_done) v_r <= mul_res ^ (mul_res >> MIX_R);
      B_WMUL2: if (mul_done) h_r <= h_r ^ mul_res;
      B_HMUL: begin
        if (mul_done) begin
          h_r <= mul_res;
          if (!last_byte) k_r <= k_r + IDX_W'(1);
        end
      end
      B_TMUL:  if (mul_done) h_r <= mul_res;
      B_FIN:   if (mul_done) h_r <= mul_res ^ (mul_res >> MIX_R);
      B_DIV:   if (div_done) pos_r <= {job.fidx, div_rem};
      B_MEM_CHK: begin
        if (job.mode == MODE_QUERY && !bit_set) found_r <= 1'b0;
      end
      B_NEXT:  seed_r <= seed_r + IDX_W'(1);
      default: begin
        p_r <= p_r;
      end
    endcase
  end

endmodule : ckbf_back
`default_nettype wire

// File: design/canonical_kmer_bloom_filter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// canonical_kmer_bloom_filter
// Canonical b-mer Bloom filter with MurmurHash64A positions over four
// partition filters.
// ----------------------------------------------------------------------------
// Sequence bytes enter one word per cycle while in_tready is high, with their
// mode and filter index; the mode and filter of the word that completes a
// b-mer apply to it. Each completed b-mer is queued (two deep, one buffer
// bank per slot) and worked off by a back-end sequencer, so bytes of the next
// b-mer keep flowing while one is hashed. Per b-mer the back end runs the
// canonical check, len*M, then per seed the byte reads, the multiplies of each
// full 8-byte word and of the tail, the finalizer, the bit-serial modulo and
// the filter word access, on the shared 64-bit multiplier (three 32x32
// partial products) and the one-bit-per-cycle remainder. The default is a
// 15-byte b-mer and 5 seeds. Inserts give no result; a query gives one word
// whose bit 0 is found. After reset the filter store is cleared one 32-bit
// word a cycle, all 32768 words, during which no sequence word is taken
// (configuration writes are).
// ----------------------------------------------------------------------------
module canonical_kmer_bloom_filter
  import ckbf_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire logic [7:0]       in_tdata,   // [7:0] base
  input  wire logic [2:0]       in_tuser,   // [0] mode, [2:1] filter_index
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  output logic [7:0]            out_tdata,  // [0] found, [7:1] zero
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data
);

  logic [LEN_W-1:0] bmer_len_r;
  logic [HC_W-1:0]  hash_count_r;
  logic [MOD_W-1:0] filter_bits_r;
  cfg_t             cfg;

  logic               job_valid, job_pop, clearing;
  job_t               job;
  kwr_t               kwr;
  logic [KADDR_W-1:0] kra_addr, krb_addr;
  logic [7:0]         kd_a, kd_b;

  assign cfg_ready = 1'b1;

  // Config registers; to be written only while no b-mer is in flight.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bmer_len_r    <= LEN_W'(15);
      hash_count_r  <= HC_W'(5);
      filter_bits_r <= MOD_W'(MAX_FILTER_BITS);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_BMER_LEN:    bmer_len_r    <= cfg_data[LEN_W-1:0];
        REG_HASH_COUNT:  hash_count_r  <= cfg_data[HC_W-1:0];
        REG_FILTER_BITS: filter_bits_r <= cfg_data[MOD_W-1:0];
        default:         bmer_len_r    <= bmer_len_r;
      endcase
    end
  end

  // Out-of-range length and modulus are clamped here once.
  always_comb begin
    if (bmer_len_r == '0) begin
      cfg.len = LEN_W'(1);
    end else if (bmer_len_r > LEN_W'(MAX_BMER)) begin
      cfg.len = LEN_W'(MAX_BMER);
    end else begin
      cfg.len = bmer_len_r;
    end
    if (filter_bits_r == '0) begin
      cfg.modulus = MOD_W'(1);
    end else if (filter_bits_r > MOD_W'(MAX_FILTER_BITS)) begin
      cfg.modulus = MOD_W'(MAX_FILTER_BITS);
    end else begin
      cfg.modulus = filter_bits_r;
    end
    cfg.hash_count = hash_count_r;
  end

  ckbf_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata (in_tdata),
    .in_tuser (in_tuser),
    .clearing (clearing),
    .kwr      (kwr),
    .job_valid(job_valid),
    .job      (job),
    .job_pop  (job_pop)
  );

  // Two copies of the b-mer buffer so a byte and its mirror read together.
  ckbf_ram #(.WIDTH(8), .DEPTH(2 * MAX_BMER)) u_kbuf_a (
    .clk  (clk),
    .we   (kwr.en),
    .waddr(kwr.addr),
    .wdata(kwr.data),
    .raddr(kra_addr),
    .rdata(kd_a)
  );

  ckbf_ram #(.WIDTH(8), .DEPTH(2 * MAX_BMER)) u_kbuf_b (
    .clk  (clk),
    .we   (kwr.en),
    .waddr(kwr.addr),
    .wdata(kwr.data),
    .raddr(krb_addr),
    .rdata(kd_b)
  );

  ckbf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .job_valid (job_valid),
    .job       (job),
    .job_pop   (job_pop),
    .clearing  (clearing),
    .kra_addr  (kra_addr),
    .krb_addr  (krb_addr),
    .kd_a      (kd_a),
    .kd_b      (kd_b),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  // The back end never retires a job that is not queued.
  a_pop_has_job: assert property (@(posedge clk) disable iff (!rst_n)
    job_pop |-> job_valid)
    else $error("job popped from empty queue");

  // No sequence word is taken while the store is being cleared.
  a_no_input_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !in_tready)
    else $error("input accepted during clear pass");

  // A result only appears when a query job retires.
  a_result_from_query: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(job_pop && job.mode == MODE_QUERY))
    else $error("result without a retiring query");

endmodule : canonical_kmer_bloom_filter
`default_nettype wire
